FILE: rtl/core/ftt_pkg.sv
// Shared types and constants for the frame task timer table.
// Holds opcodes, result kinds, sequencer states, the slot record and the evaluation result.
// No dependencies.
package ftt_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ADD_ABS = 2'd1,
        OP_ADD_DLY = 2'd2,
        OP_ADD_PER = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_FIRED       = 3'd0,
        KIND_TICK_DONE   = 3'd1,
        KIND_ACCEPTED    = 3'd2,
        KIND_REJ_FULL    = 3'd3,
        KIND_REJ_ZERO    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    // One timer slot as stored in the slot memory
    typedef struct packed {
        logic        oneshot;
        logic [31:0] deadline;
        logic [15:0] period;
        logic [15:0] phase;
        logic [15:0] occurrence;
        logic [15:0] remaining;
        logic        limited;
        logic [15:0] handle;
    } t_slot;

    // Verdict of the per-slot tick evaluation
    typedef struct packed {
        logic        fire;
        logic        free;
        logic        wr;
        logic [15:0] arg;
    } t_eval;

endpackage

FILE: rtl/core/frame_task_timer_table_core.sv
// Frame task timer table: top level with control sequencer and result register.
// Depends on ftt_pkg, ftt_slot_mem and ftt_slot_eval.
//
// A table of NUM_SLOTS timer slots. An add beat (one-shot absolute, one-shot
// delay or periodic) takes the lowest free slot, or is rejected if none is free
// or a periodic period is zero, and answers with one result beat in the cycle
// after it is taken, so adds run at one per cycle while the output drains. A
// tick beat walks every slot in slot order through the slot memory, one slot a
// cycle unless a fired beat waits on a stalled output: the read of slot i
// overlaps the evaluation and write-back of slot i-1. It emits a fired beat per
// firing task and then a closing tick-done beat with last set; no further input
// beat is taken until that closing beat is issued. Slot occupancy lives in
// flip-flops cleared by reset; the slot records live in one memory that needs
// no clearing, since a record is only used once its slot has been filled.
module frame_task_timer_table_core #(
    parameter int NUM_SLOTS = ftt_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_frame_now,
    input  logic [31:0] i_target_frame,
    input  logic [15:0] i_period,
    input  logic [15:0] i_repeat_count,
    input  logic [15:0] i_task_handle,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_fired_handle,
    output logic [15:0] o_fire_argument,
    output logic [3:0]  o_slot_index,
    output logic        o_last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    // control state
    ftt_pkg::t_state        r_state, n_state;
    logic [NUM_SLOTS-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_ev_valid, n_ev_valid;
    logic [IDX_W-1:0]       r_ev_idx, n_ev_idx;
    logic [31:0]            r_now, n_now;

    // result register
    logic                   r_out_valid, n_out_valid;
    ftt_pkg::t_kind         r_kind, n_kind;
    logic [15:0]            r_handle, n_handle;
    logic [15:0]            r_arg, n_arg;
    logic [3:0]             r_slot, n_slot;
    logic                   r_last, n_last;

    // sequencer outputs
    logic in_ready;
    logic walk_en;
    logic done_en;

    logic out_free;
    logic in_acc;
    logic walk_end;
    logic more;
    logic ev_go;

    // free slot search
    logic             free_found;
    logic [IDX_W-1:0] free_idx;

    // memory ports
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    ftt_pkg::t_slot   mem_wdata;
    logic             mem_re;
    ftt_pkg::t_slot   mem_rdata;
    ftt_pkg::t_slot   new_entry;

    ftt_pkg::t_eval   ev_res;
    ftt_pkg::t_slot   ev_entry;

    logic [IDX_W+3:0] free_idx_wide;
    logic [IDX_W+3:0] ev_idx_wide;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign more     = (r_idx < CNT_W'(NUM_SLOTS));
    assign walk_end = !more && !r_ev_valid;
    // evaluation stage moves on unless it has a beat to emit and nowhere to put it
    assign ev_go    = walk_en && (!r_ev_valid || !ev_res.fire || out_free);

    assign free_idx_wide = {4'd0, free_idx};
    assign ev_idx_wide   = {4'd0, r_ev_idx};

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ftt_pkg::ST_IDLE: begin
                if (in_acc && (i_opcode == ftt_pkg::OP_TICK)) begin
                    n_state = ftt_pkg::ST_WALK;
                end
            end
            ftt_pkg::ST_WALK: begin
                if (walk_end) begin
                    n_state = ftt_pkg::ST_DONE;
                end
            end
            ftt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ftt_pkg::ST_IDLE;
                end
            end
            default: n_state = ftt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        walk_en  = 1'b0;
        done_en  = 1'b0;
        case (r_state)
            ftt_pkg::ST_IDLE: in_ready = 1'b1;
            ftt_pkg::ST_WALK: walk_en  = 1'b1;
            ftt_pkg::ST_DONE: done_en  = 1'b1;
            default: ;
        endcase
    end

    assign o_in_stall = !(in_ready && out_free);

    // record for a newly filled slot
    always_comb begin
        new_entry            = '0;
        new_entry.handle     = i_task_handle;
        if (i_opcode == ftt_pkg::OP_ADD_PER) begin
            new_entry.period    = i_period;
            new_entry.remaining = i_repeat_count;
            new_entry.limited   = (i_repeat_count != 16'd0);
        end else begin
            new_entry.oneshot  = 1'b1;
            new_entry.deadline = (i_opcode == ftt_pkg::OP_ADD_DLY)
                               ? (i_frame_now + i_target_frame) : i_target_frame;
        end
    end

    ftt_slot_eval u_eval (
        .i_entry (mem_rdata),
        .i_valid (r_valid[r_ev_idx]),
        .i_now   (r_now),
        .o_res   (ev_res),
        .o_entry (ev_entry)
    );

    // datapath and result register
    always_comb begin
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_ev_valid  = r_ev_valid;
        n_ev_idx    = r_ev_idx;
        n_now       = r_now;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_handle    = r_handle;
        n_arg       = r_arg;
        n_slot      = r_slot;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_waddr   = r_ev_idx;
        mem_wdata   = ev_entry;
        mem_re      = 1'b0;

        if (in_acc) begin
            if (i_opcode == ftt_pkg::OP_TICK) begin
                // latch the frame and start the walk at slot 0
                n_now      = i_frame_now;
                n_idx      = '0;
                n_ev_valid = 1'b0;
            end else begin
                n_out_valid = 1'b1;
                n_handle    = i_task_handle;
                n_arg       = '0;
                n_slot      = '0;
                n_last      = 1'b1;
                if ((i_opcode == ftt_pkg::OP_ADD_PER) && (i_period == 16'd0)) begin
                    n_kind = ftt_pkg::KIND_REJ_ZERO;
                end else if (!free_found) begin
                    n_kind = ftt_pkg::KIND_REJ_FULL;
                end else begin
                    n_kind             = ftt_pkg::KIND_ACCEPTED;
                    n_slot             = free_idx_wide[3:0];
                    n_valid[free_idx]  = 1'b1;
                    mem_we             = 1'b1;
                    mem_waddr          = free_idx;
                    mem_wdata          = new_entry;
                end
            end
        end

        if (ev_go) begin
            // retire the slot under evaluation
            if (r_ev_valid) begin
                if (ev_res.fire) begin
                    n_out_valid = 1'b1;
                    n_kind      = ftt_pkg::KIND_FIRED;
                    n_handle    = mem_rdata.handle;
                    n_arg       = ev_res.arg;
                    n_slot      = ev_idx_wide[3:0];
                    n_last      = 1'b0;
                end
                if (ev_res.free) begin
                    n_valid[r_ev_idx] = 1'b0;
                end
                mem_we = ev_res.wr;
            end
            // advance the read one slot ahead
            if (more) begin
                mem_re     = 1'b1;
                n_ev_valid = 1'b1;
                n_ev_idx   = r_idx[IDX_W-1:0];
                n_idx      = r_idx + CNT_W'(1);
            end else begin
                n_ev_valid = 1'b0;
            end
        end

        if (done_en && out_free) begin
            n_out_valid = 1'b1;
            n_kind      = ftt_pkg::KIND_TICK_DONE;
            n_handle    = '0;
            n_arg       = '0;
            n_slot      = '0;
            n_last      = 1'b1;
        end
    end

    ftt_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .ADDR_W    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftt_pkg::ST_IDLE;
            r_valid     <= '0;
            r_idx       <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_idx       <= n_idx;
            r_ev_valid  <= n_ev_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ev_idx <= n_ev_idx;
        r_now    <= n_now;
        r_kind   <= n_kind;
        r_handle <= n_handle;
        r_arg    <= n_arg;
        r_slot   <= n_slot;
        r_last   <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_fired_handle  = r_handle;
    assign o_fire_argument = r_arg;
    assign o_slot_index    = r_slot;
    assign o_last          = r_last;

endmodule

FILE: rtl/core/ftt_slot_mem.sv
// Slot record memory: one write port, one read port, registered read data.
// Depends on ftt_pkg for the slot record type.
module ftt_slot_mem #(
    parameter int NUM_SLOTS = ftt_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_W    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  ftt_pkg::t_slot        i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr,
    output ftt_pkg::t_slot        o_rdata
);

    ftt_pkg::t_slot mem [NUM_SLOTS];
    ftt_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ftt_slot_eval.sv
// Tick evaluation of one slot: fire decision, freeing and updated record.
// Depends on ftt_pkg for the slot record and verdict types.
module ftt_slot_eval (
    input  ftt_pkg::t_slot i_entry,
    input  logic           i_valid,
    input  logic [31:0]    i_now,
    output ftt_pkg::t_eval o_res,
    output ftt_pkg::t_slot o_entry
);

    logic [15:0] phase_inc;
    logic [15:0] rem_dec;
    logic        per_fire;

    assign phase_inc = i_entry.phase + 16'd1;
    assign rem_dec   = i_entry.remaining - 16'd1;
    assign per_fire  = (i_entry.phase == 16'd0);

    always_comb begin
        o_entry   = i_entry;
        o_res     = '0;
        if (i_valid) begin
            if (i_entry.oneshot) begin
                o_res.fire = (i_entry.deadline <= i_now);
                o_res.free = o_res.fire;
            end else begin
                o_res.fire = per_fire;
                o_res.arg  = i_entry.occurrence;
                o_res.free = per_fire && i_entry.limited && (rem_dec == 16'd0);
                o_res.wr   = !o_res.free;
                if (per_fire) begin
                    o_entry.occurrence = i_entry.occurrence + 16'd1;
                    if (i_entry.limited) begin
                        o_entry.remaining = rem_dec;
                    end
                end
                // phase counts ticks modulo the period
                o_entry.phase = (phase_inc >= i_entry.period) ? 16'd0 : phase_inc;
            end
        end
    end

endmodule
